// ----- rtl/nsc_pkg.sv -----
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types, character codes and character-class helpers for the
// sentence checker.
// ----------------------------------------------------------------------------
`default_nettype none

package nsc_pkg;

  // parser phase, one-hot
  typedef enum logic [11:0] {
    PH_DOLLAR   = 12'b0000_0000_0001,
    PH_G        = 12'b0000_0000_0010,
    PH_P        = 12'b0000_0000_0100,
    PH_L1       = 12'b0000_0000_1000,
    PH_L2       = 12'b0000_0001_0000,
    PH_L3       = 12'b0000_0010_0000,
    PH_AFTERFMT = 12'b0000_0100_0000,
    PH_FIELDS   = 12'b0000_1000_0000,
    PH_HEX1     = 12'b0001_0000_0000,
    PH_HEX2     = 12'b0010_0000_0000,
    PH_DONE     = 12'b0100_0000_0000,
    PH_ERROR    = 12'b1000_0000_0000
  } phase_e;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChPeriod = 8'h2E;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChG      = 8'h47;
  localparam logic [7:0] ChP      = 8'h50;

  localparam logic [7:0] FieldMax = 8'hFF;

  // hex digit decode result
  typedef struct packed {
    logic       valid;
    logic [3:0] nibble;
  } hex_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A]});
  endfunction

  function automatic logic is_field_char(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                      ChSpace, ChComma, ChPeriod});
  endfunction

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.valid  = 1'b1;
    h.nibble = c[3:0];
    if (c inside {[8'h30:8'h39]}) begin
      h.nibble = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      h.nibble = c[3:0] + 4'd9;
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/nmea_sentence_checker_core.sv -----
// ----------------------------------------------------------------------------
// nmea_sentence_checker_core
// Byte-at-a-time grammar and checksum checker for NMEA 0183 style lines.
// ----------------------------------------------------------------------------
// usage
//   input channel: one sentence byte per word, line_end_i flags the last byte
//   of the line; handshake in_valid_i / in_ready_o
//   output channel: one result word per line, issued for the line_end byte
//   only; handshake out_valid_o / out_ready_i
//   a byte accepted is held in the input register and parsed from there when
//   the parse stage advances; if it ends the line, its result is loaded into
//   the output register in that step and shows on the outputs from there,
//   where the receiver can take it
//   throughput is one byte per cycle while the result slot is free or draining;
//   the only loop is the parser state update, computed from the input register
//   when the receiver stalls a finished result waits in the output register;
//   one more byte may sit in the input register, then in_ready_o drops
//   reset clears both valid flags and returns the parser to expect-dollar
//   with checksum, letters, hex value and field count at zero
//   an ill-formed line returns all-zero payload with well_formed_o low
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_checker_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  sentence_byte_i,
  input  wire logic        line_end_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             well_formed_o,
  output logic             checksum_ok_o,
  output logic [7:0]       computed_checksum_o,
  output logic [7:0]       received_checksum_o,
  output logic [23:0]      format_code_o,
  output logic [7:0]       field_count_o
);

  // input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // parser state
  nsc_pkg::phase_e phase_q, phase_d;
  logic [7:0]      xor_q, xor_d;
  logic [23:0]     fmt_q, fmt_d;
  logic [7:0]      hex_q, hex_d;
  logic [7:0]      fields_q, fields_d;

  // result register
  logic        out_vld_q, out_vld_d;
  logic        wf_q, ck_ok_q;
  logic [7:0]  comp_q, recv_q, cnt_q;
  logic [23:0] fmt_out_q;

  logic           advance;   // input register word is consumed this cycle
  logic           in_fire;
  logic           line_ok;
  logic           res_load;
  nsc_pkg::hex_t  hx;
  logic [7:0]     fields_inc;

  // the parse stage moves whenever the result slot is free or draining
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;
  assign res_load   = advance && in_last_q;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= sentence_byte_i;
      in_last_q <= line_end_i;
    end
  end

  // per-byte parser step
  assign hx         = nsc_pkg::hex_digit(in_byte_q);
  assign fields_inc = (fields_q == nsc_pkg::FieldMax) ? fields_q : fields_q + 8'd1;

  always_comb begin
    phase_d  = phase_q;
    xor_d    = xor_q;
    fmt_d    = fmt_q;
    hex_d    = hex_q;
    fields_d = fields_q;
    case (phase_q)
      nsc_pkg::PH_DOLLAR: begin
        phase_d = (in_byte_q == nsc_pkg::ChDollar) ? nsc_pkg::PH_G : nsc_pkg::PH_ERROR;
      end
      nsc_pkg::PH_G: begin
        if (in_byte_q == nsc_pkg::ChG) begin
          xor_d   = xor_q ^ in_byte_q;
          phase_d = nsc_pkg::PH_P;
        end else begin
          phase_d = nsc_pkg::PH_ERROR;
        end
      end
      nsc_pkg::PH_P: begin
        if (in_byte_q == nsc_pkg::ChP) begin
          xor_d   = xor_q ^ in_byte_q;
          phase_d = nsc_pkg::PH_L1;
        end else begin
          phase_d = nsc_pkg::PH_ERROR;
        end
      end
      nsc_pkg::PH_L1, nsc_pkg::PH_L2, nsc_pkg::PH_L3: begin
        if (nsc_pkg::is_upper(in_byte_q)) begin
          xor_d = xor_q ^ in_byte_q;
          fmt_d = {fmt_q[15:0], in_byte_q};
          case (phase_q)
            nsc_pkg::PH_L1: phase_d = nsc_pkg::PH_L2;
            nsc_pkg::PH_L2: phase_d = nsc_pkg::PH_L3;
            default:        phase_d = nsc_pkg::PH_AFTERFMT;
          endcase
        end else begin
          phase_d = nsc_pkg::PH_ERROR;
        end
      end
      nsc_pkg::PH_AFTERFMT: begin
        if (in_byte_q == nsc_pkg::ChComma) begin
          xor_d    = xor_q ^ in_byte_q;
          fields_d = fields_inc;
          phase_d  = nsc_pkg::PH_FIELDS;
        end else if (in_byte_q == nsc_pkg::ChStar) begin
          phase_d = nsc_pkg::PH_HEX1;
        end else begin
          phase_d = nsc_pkg::PH_ERROR;
        end
      end
      nsc_pkg::PH_FIELDS: begin
        if (in_byte_q == nsc_pkg::ChStar) begin
          phase_d = nsc_pkg::PH_HEX1;
        end else if (nsc_pkg::is_field_char(in_byte_q)) begin
          xor_d = xor_q ^ in_byte_q;
          if (in_byte_q == nsc_pkg::ChComma) begin
            fields_d = fields_inc;
          end
        end else begin
          phase_d = nsc_pkg::PH_ERROR;
        end
      end
      nsc_pkg::PH_HEX1, nsc_pkg::PH_HEX2: begin
        if (hx.valid) begin
          hex_d   = {hex_q[3:0], hx.nibble};
          phase_d = (phase_q == nsc_pkg::PH_HEX1) ? nsc_pkg::PH_HEX2 : nsc_pkg::PH_DONE;
        end else begin
          phase_d = nsc_pkg::PH_ERROR;
        end
      end
      default: begin
        // trailing bytes after the checksum, or already failed
        phase_d = nsc_pkg::PH_ERROR;
      end
    endcase
  end

  assign line_ok = (phase_d == nsc_pkg::PH_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= nsc_pkg::PH_DOLLAR;
      xor_q    <= 8'd0;
      fmt_q    <= 24'd0;
      hex_q    <= 8'd0;
      fields_q <= 8'd0;
    end else if (advance) begin
      if (in_last_q) begin
        // line done, back to idle for the next sentence
        phase_q  <= nsc_pkg::PH_DOLLAR;
        xor_q    <= 8'd0;
        fmt_q    <= 24'd0;
        hex_q    <= 8'd0;
        fields_q <= 8'd0;
      end else begin
        phase_q  <= phase_d;
        xor_q    <= xor_d;
        fmt_q    <= fmt_d;
        hex_q    <= hex_d;
        fields_q <= fields_d;
      end
    end
  end

  // result register
  always_comb begin
    out_vld_d = out_vld_q;
    if (res_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      wf_q      <= line_ok;
      ck_ok_q   <= line_ok && (hex_d == xor_d);
      comp_q    <= line_ok ? xor_d    : 8'd0;
      recv_q    <= line_ok ? hex_d    : 8'd0;
      fmt_out_q <= line_ok ? fmt_d    : 24'd0;
      cnt_q     <= line_ok ? fields_d : 8'd0;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign well_formed_o       = wf_q;
  assign checksum_ok_o       = ck_ok_q;
  assign computed_checksum_o = comp_q;
  assign received_checksum_o = recv_q;
  assign format_code_o       = fmt_out_q;
  assign field_count_o       = cnt_q;

  // a byte that does not end the line never leaves the parser idle
  a_mid_line_not_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !in_last_q |=> phase_q != nsc_pkg::PH_DOLLAR)
    else $error("parser idle after a mid-line byte");

  // the line-end byte returns the parser to its cleared state
  a_line_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> phase_q == nsc_pkg::PH_DOLLAR && xor_q == 8'd0 &&
      fields_q == 8'd0 && hex_q == 8'd0 && fmt_q == 24'd0)
    else $error("parser not cleared after line end");

  // a good checksum implies a well-formed line with matching values
  a_ck_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && ck_ok_q |-> wf_q && (comp_q == recv_q))
    else $error("checksum_ok without match");

  // an ill-formed line carries an all-zero payload
  a_bad_line_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !wf_q |-> !ck_ok_q && comp_q == 8'd0 && recv_q == 8'd0 &&
      fmt_out_q == 24'd0 && cnt_q == 8'd0)
    else $error("ill-formed line with nonzero payload");

  // input side only backs up when the result slot is blocked
  a_ready_low_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q && out_vld_q && !out_ready_i)
    else $error("in_ready low without downstream stall");

endmodule

`default_nettype wire

// ----- verif/nmea_sentence_checker_core_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nmea_sentence_checker_core_checker
// Watches both channels of the sentence checker. It parses every accepted
// byte with its own model of the grammar, queues the verdict expected for
// each line end, and compares every returned word field by field.
// ----------------------------------------------------------------------------

module nmea_sentence_checker_core_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  sentence_byte_i,
  input  logic        line_end_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        well_formed_i,
  input  logic        checksum_ok_i,
  input  logic [7:0]  computed_checksum_i,
  input  logic [7:0]  received_checksum_i,
  input  logic [23:0] format_code_i,
  input  logic [7:0]  field_count_i,
  output int          mismatch_count_o,
  output int          pending_count_o
);

  typedef struct packed {
    logic        well_formed;
    logic        checksum_ok;
    logic [7:0]  computed_checksum;
    logic [7:0]  received_checksum;
    logic [23:0] format_code;
    logic [7:0]  field_count;
  } line_verdict_t;

  nsc_pkg::phase_e parse_phase;
  logic [7:0]      line_xor;
  logic [23:0]     format_letters;
  logic [7:0]      hex_value;
  logic [7:0]      comma_count;
  line_verdict_t   verdict_q[$];
  int              mismatches = 0;

  task automatic clear_line();
    parse_phase    = nsc_pkg::PH_DOLLAR;
    line_xor       = 8'h00;
    format_letters = 24'h0;
    hex_value      = 8'h00;
    comma_count    = 8'h00;
  endtask

  // one byte through the grammar; a line end queues the verdict
  task automatic parse_byte(input logic [7:0] c, input logic last);
    logic [7:0]    nib;
    logic          is_hex;
    logic          ok;
    line_verdict_t v;
    case (parse_phase)
      nsc_pkg::PH_DOLLAR:
        parse_phase = (c == nsc_pkg::ChDollar) ? nsc_pkg::PH_G : nsc_pkg::PH_ERROR;
      nsc_pkg::PH_G, nsc_pkg::PH_P: begin
        if (c == ((parse_phase == nsc_pkg::PH_G) ? nsc_pkg::ChG : nsc_pkg::ChP)) begin
          line_xor    = line_xor ^ c;
          parse_phase = parse_phase.next();
        end else begin
          parse_phase = nsc_pkg::PH_ERROR;
        end
      end
      nsc_pkg::PH_L1, nsc_pkg::PH_L2, nsc_pkg::PH_L3: begin
        if (c >= "A" && c <= "Z") begin
          line_xor       = line_xor ^ c;
          format_letters = {format_letters[15:0], c};
          parse_phase    = parse_phase.next();
        end else begin
          parse_phase = nsc_pkg::PH_ERROR;
        end
      end
      nsc_pkg::PH_AFTERFMT: begin
        if (c == nsc_pkg::ChComma) begin
          line_xor = line_xor ^ c;
          if (comma_count != nsc_pkg::FieldMax) comma_count++;
          parse_phase = nsc_pkg::PH_FIELDS;
        end else if (c == nsc_pkg::ChStar) begin
          parse_phase = nsc_pkg::PH_HEX1;
        end else begin
          parse_phase = nsc_pkg::PH_ERROR;
        end
      end
      nsc_pkg::PH_FIELDS: begin
        if (c == nsc_pkg::ChStar) begin
          parse_phase = nsc_pkg::PH_HEX1;
        end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
                     (c >= "0" && c <= "9") || c == nsc_pkg::ChSpace ||
                     c == nsc_pkg::ChComma || c == nsc_pkg::ChPeriod) begin
          line_xor = line_xor ^ c;
          if (c == nsc_pkg::ChComma && comma_count != nsc_pkg::FieldMax) comma_count++;
        end else begin
          parse_phase = nsc_pkg::PH_ERROR;
        end
      end
      nsc_pkg::PH_HEX1, nsc_pkg::PH_HEX2: begin
        is_hex = 1'b1;
        nib    = 8'h00;
        if (c >= "0" && c <= "9") begin
          nib = c - 8'h30;
        end else if (c >= "A" && c <= "F") begin
          nib = c - 8'h41 + 8'd10;
        end else if (c >= "a" && c <= "f") begin
          nib = c - 8'h61 + 8'd10;
        end else begin
          is_hex = 1'b0;
        end
        if (is_hex) begin
          hex_value   = {hex_value[3:0], nib[3:0]};
          parse_phase = parse_phase.next();
        end else begin
          parse_phase = nsc_pkg::PH_ERROR;
        end
      end
      default: parse_phase = nsc_pkg::PH_ERROR;
    endcase

    if (last) begin
      ok = (parse_phase == nsc_pkg::PH_DONE);
      v.well_formed       = ok;
      v.checksum_ok       = ok && (hex_value == line_xor);
      v.computed_checksum = ok ? line_xor : 8'h00;
      v.received_checksum = ok ? hex_value : 8'h00;
      v.format_code       = ok ? format_letters : 24'h0;
      v.field_count       = ok ? comma_count : 8'h00;
      verdict_q = {verdict_q, v};
      clear_line();
    end
  endtask

  task automatic report(input string name, input logic [23:0] want,
                        input logic [23:0] got);
    $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    line_verdict_t got;
    line_verdict_t want;
    if (!rst_ni) begin
      clear_line();
      verdict_q.delete();
      pending_count_o  <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      if (in_valid_i && in_ready_i) parse_byte(sentence_byte_i, line_end_i);
      if (out_valid_i && out_ready_i) begin
        got = '{well_formed_i, checksum_ok_i, computed_checksum_i,
                received_checksum_i, format_code_i, field_count_i};
        if (verdict_q.size() == 0) begin
          $display("%0t: result expected none, actual %0h", $time, got);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          if (got.well_formed !== want.well_formed)
            report("well_formed", want.well_formed, got.well_formed);
          if (got.checksum_ok !== want.checksum_ok)
            report("checksum_ok", want.checksum_ok, got.checksum_ok);
          if (got.computed_checksum !== want.computed_checksum)
            report("computed_checksum", want.computed_checksum, got.computed_checksum);
          if (got.received_checksum !== want.received_checksum)
            report("received_checksum", want.received_checksum, got.received_checksum);
          if (got.format_code !== want.format_code)
            report("format_code", want.format_code, got.format_code);
          if (got.field_count !== want.field_count)
            report("field_count", want.field_count, got.field_count);
        end
      end
      pending_count_o  <= verdict_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// ----- verif/nmea_sentence_checker_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nmea_sentence_checker_core_tb
// Feeds sentence lines into the checker: a few hand-built lines first, then
// random well-formed sentences, damaged sentences and byte noise, with bursty
// input and a stalling receiver. The checker module judges every result.
// ----------------------------------------------------------------------------

module nmea_sentence_checker_core_tb;

  localparam int RandomWords = 1350;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  sentence_byte_i;
  logic        line_end_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        well_formed_o;
  logic        checksum_ok_o;
  logic [7:0]  computed_checksum_o;
  logic [7:0]  received_checksum_o;
  logic [23:0] format_code_o;
  logic [7:0]  field_count_o;

  int          mismatch_count;
  int          pending_count;

  // sender bookkeeping
  logic [7:0]  line_q[$];
  int          burst_left = 0;
  int          words_sent = 0;

  // receiver stall pattern
  int          stall_tick = 0;
  int          stall_mode = 0;

  always #10 clk_i = ~clk_i;

  nmea_sentence_checker_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .sentence_byte_i    (sentence_byte_i),
    .line_end_i         (line_end_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .well_formed_o      (well_formed_o),
    .checksum_ok_o      (checksum_ok_o),
    .computed_checksum_o(computed_checksum_o),
    .received_checksum_o(received_checksum_o),
    .format_code_o      (format_code_o),
    .field_count_o      (field_count_o)
  );

  nmea_sentence_checker_core_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .sentence_byte_i    (sentence_byte_i),
    .line_end_i         (line_end_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .well_formed_i      (well_formed_o),
    .checksum_ok_i      (checksum_ok_o),
    .computed_checksum_i(computed_checksum_o),
    .received_checksum_i(received_checksum_o),
    .format_code_i      (format_code_o),
    .field_count_i      (field_count_o),
    .mismatch_count_o   (mismatch_count),
    .pending_count_o    (pending_count)
  );

  // receiver: the stall mode is re-picked at random on a periodic tick
  // modes: always ready, coin flip, and two periodic ready patterns, one dense and one sparse
  always @(negedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 128 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= (stall_tick % 5) < 3;
      default: out_ready_i <= (stall_tick % 32) == 0;
    endcase
  end

  // one byte onto the end of the line being built
  task automatic add_byte(input logic [7:0] b);
    line_q = {line_q, b};
  endtask

  // one word on the input channel; bursts of random length with random gaps
  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 7);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        // garbage on the payload while valid is low
        in_valid_i      <= 1'b0;
        sentence_byte_i <= 8'($urandom_range(0, 255));
        line_end_i      <= 1'($urandom_range(0, 1));
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i      <= 1'b1;
    sentence_byte_i <= b;
    line_end_i      <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    words_sent++;
    @(negedge clk_i);
  endtask

  // whole line, line end flagged on its last byte
  task automatic send_line();
    int k;
    for (k = 0; k < line_q.size(); k++) send_word(line_q[k], k == line_q.size() - 1);
  endtask

  task automatic load_text(input string s);
    int k;
    line_q = {};
    for (k = 0; k < s.len(); k++) add_byte(s[k]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  // line ends in the star; xor runs from after the dollar up to the star
  task automatic append_checksum(input logic good, input logic lower);
    logic [7:0] sum;
    logic [7:0] hx;
    int         k;
    sum = 8'h00;
    for (k = 1; k < line_q.size() - 1; k++) sum = sum ^ line_q[k];
    hx = good ? sum : sum ^ 8'($urandom_range(1, 255));
    add_byte(hex_char(hx[7:4], lower));
    add_byte(hex_char(hx[3:0], lower));
  endtask

  function automatic logic [7:0] field_char();
    case ($urandom_range(0, 5))
      0: return 8'h41 + 8'($urandom_range(0, 25));
      1: return 8'h61 + 8'($urandom_range(0, 25));
      2: return 8'h30 + 8'($urandom_range(0, 9));
      3: return nsc_pkg::ChSpace;
      4: return nsc_pkg::ChComma;
      default: return nsc_pkg::ChPeriod;
    endcase
  endfunction

  // n_chars counts the field part including the leading comma; 0 = no fields
  task automatic build_sentence(input int n_chars, input logic comma_only,
                                input logic good, input logic lower);
    int k;
    line_q = '{nsc_pkg::ChDollar, nsc_pkg::ChG, nsc_pkg::ChP};
    repeat (3) add_byte(8'h41 + 8'($urandom_range(0, 25)));
    if (n_chars > 0) add_byte(nsc_pkg::ChComma);
    for (k = 1; k < n_chars; k++) add_byte(comma_only ? nsc_pkg::ChComma : field_char());
    add_byte(nsc_pkg::ChStar);
    append_checksum(good, lower);
  endtask

  initial begin
    int random_start;
    int line_idx;
    int pick;
    int k;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    sentence_byte_i = 8'h00;
    line_end_i      = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: good line with letter, digit, space and period fields,
    // lower-case checksum
    load_text("$GPAZA,z0 9.*");
    append_checksum(1'b1, 1'b1);
    send_line();
    // lone line-end bytes at both extremes of the byte range
    line_q = '{8'h00};
    send_line();
    line_q = '{8'hFF};
    send_line();
    // no fields, wrong checksum in upper case
    load_text("$GPABC*");
    append_checksum(1'b0, 1'b0);
    send_line();

    // random lines until the word budget is used up
    random_start = words_sent;
    line_idx     = 0;
    while (words_sent - random_start < RandomWords) begin
      if (line_idx == 3) begin
        // exactly 255 commas, reaching the saturation value without clipping
        build_sentence(255, 1'b1, 1'b1, 1'b0);
      end else if (line_idx == 20) begin
        // field count saturates
        build_sentence(258, 1'b1, 1'b1, 1'b1);
      end else begin
        pick = $urandom_range(0, 99);
        build_sentence(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20), 1'b0,
                       $urandom_range(0, 4) != 0, 1'($urandom_range(0, 1)));
        if (pick >= 70 && pick < 85) begin
          // damaged sentence
          case ($urandom_range(0, 3))
            0: line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
            1: begin
              k = $urandom_range(1, line_q.size() - 1);
              repeat (k) void'(line_q.pop_back());
            end
            2: repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
            default: line_q.delete($urandom_range(0, line_q.size() - 1));
          endcase
        end else if (pick >= 85) begin
          // plain byte noise
          line_q = {};
          repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
        end
      end
      send_line();
      line_idx++;
    end
    in_valid_i <= 1'b0;

    // drain outstanding results, then idle a while for anything stray
    while (pending_count != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
